>>> rtl/ncr_pkg.sv
// Shared types and constants for the neighbor cache with next-hop selection.
// No dependencies; every other file refers to this package by scoped names.
package ncr_pkg;

	localparam int unsigned IP_W   = 32;
	localparam int unsigned MAC_W  = 48;
	localparam int unsigned CFG_AW = 2;

	typedef logic [IP_W-1:0]  ip_t;
	typedef logic [MAC_W-1:0] mac_t;

	// Item kinds on the kind input.
	localparam logic KIND_LEARN   = 1'b0;
	localparam logic KIND_RESOLVE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_OWN_IP  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_SUBNET  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_GATEWAY = 2'd2;

	// Request from the item stage into the table.
	typedef struct packed {
		logic learn;   // write key/mac into the table at this edge
		ip_t  key;     // address searched (learn address or next hop)
		mac_t mac;     // hardware address to learn
	} table_req_t;

	// Combinational answer of the table for the current request.
	typedef struct packed {
		logic hit;     // key found among valid entries
		mac_t mac;     // MAC of the lowest matching entry, zero on miss
		logic stored;  // a learn would land in a slot
	} table_rsp_t;

endpackage

>>> rtl/ncr_hop.sv
// Next-hop selection: the destination when it lies in the own subnet, else the gateway.
// Depends on ncr_pkg for the address type.
module ncr_hop (
	input  ncr_pkg::ip_t own_ip,
	input  ncr_pkg::ip_t subnet_mask,
	input  ncr_pkg::ip_t gateway_addr,
	input  ncr_pkg::ip_t dst,
	output ncr_pkg::ip_t hop
);

	logic on_link;

	assign on_link = ((dst ^ own_ip) & subnet_mask) == '0;
	assign hop     = on_link ? dst : gateway_addr;

endmodule

>>> rtl/ncr_table.sv
// Neighbor table: entry storage, parallel compare of all slots, lowest-slot pick
// for lookup and for learn. Depends on ncr_pkg for the request and response types.
module ncr_table #(
	parameter int unsigned ENTRIES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ncr_pkg::table_req_t req,
	output ncr_pkg::table_rsp_t rsp
);

	ncr_pkg::ip_t       entry_ip_q  [ENTRIES];
	ncr_pkg::mac_t      entry_mac_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] match_first;
	logic [ENTRIES-1:0] cand;
	logic [ENTRIES-1:0] cand_first;
	ncr_pkg::mac_t      mac_sel;

	// Compare lanes, one per slot.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (entry_ip_q[i] == req.key);
			cand[i]  = !valid_q[i] || match[i];
		end
	end

	// Isolate the lowest set bit of each vector.
	assign match_first = match & (~match + ENTRIES'(1));
	assign cand_first  = cand & (~cand + ENTRIES'(1));

	always_comb begin
		mac_sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			mac_sel = mac_sel | (entry_mac_q[i] & {ncr_pkg::MAC_W{match_first[i]}});
		end
	end

	assign rsp.hit    = |match;
	assign rsp.mac    = mac_sel;
	assign rsp.stored = |cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.learn) begin
			valid_q <= valid_q | cand_first;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (req.learn && cand_first[i]) begin
				entry_ip_q[i]  <= req.key;
				entry_mac_q[i] <= req.mac;
			end
		end
	end

	// Slots fill from the bottom, so the valid marks are always a run of low ones.
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q + ENTRIES'(1)) & valid_q) == '0)
		else $error("valid marks are not a contiguous low run");

	// An address never sits in two valid slots.
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("address matches more than one valid slot");

	// Valid marks never drop once set.
	a_valid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $countones($past(valid_q)))
		else $error("a valid mark was lost");

	// A learn that finds no slot leaves the table untouched.
	a_full_keep: assert property (@(posedge clk) disable iff (!arst_n)
		req.learn && !rsp.stored |=> $stable(valid_q))
		else $error("rejected learn changed the valid marks");

endmodule

>>> rtl/neighbor_cache_resolve.sv
// Top level of the neighbor cache with next-hop selection: item register,
// config registers, result register. Depends on ncr_pkg, ncr_hop and ncr_table.
//
// The block takes one item per clock: busy is always low, so a transfer occurs at
// every rising edge where start is high. An item accepted at one edge is held in
// the item register for the next cycle, where the next-hop select and the
// parallel compare over all ENTRIES slots run; the result register loads at the
// following edge and done is high for exactly one cycle with each result.
// The table is updated at the same edge that loads
// the result, so the item right behind sees a learn already in place and results
// leave in the order items came in. The receiver cannot stall, and none is needed.
// A learn (kind 0) puts the pair in the lowest slot that is free or already holds
// that address and reports stored; with all slots holding other addresses it is
// dropped with stored low. A resolve (kind 1) reports the next hop, hit and the
// MAC (zero on a miss). Fields that do not belong to an item's kind read as zero.
// Configuration writes take effect at the write edge and must come while no item
// is in flight. Valid marks are cleared at reset; entry contents are not.
module neighbor_cache_resolve #(
	parameter int unsigned ENTRIES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [ncr_pkg::CFG_AW-1:0] cfg_index,
	input  logic [31:0]                cfg_data,
	// item port
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [31:0]                ip_addr,
	input  logic [47:0]                mac_addr,
	// result port
	output logic                       done,
	output logic                       hit,
	output logic [47:0]                found_mac,
	output logic [31:0]                next_hop,
	output logic                       stored
);

	// Configuration registers.
	ncr_pkg::ip_t own_ip_q;
	ncr_pkg::ip_t subnet_mask_q;
	ncr_pkg::ip_t gateway_q;

	// Item register.
	logic          vld_s1;
	logic          kind_s1;
	ncr_pkg::ip_t  ip_s1;
	ncr_pkg::mac_t mac_s1;

	// Result register.
	logic          done_q;
	logic          hit_q;
	ncr_pkg::mac_t found_mac_q;
	ncr_pkg::ip_t  next_hop_q;
	logic          stored_q;

	ncr_pkg::ip_t        hop;
	logic                is_resolve;
	ncr_pkg::table_req_t treq;
	ncr_pkg::table_rsp_t trsp;

	// The datapath takes an item every cycle.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= '0;
			subnet_mask_q <= '0;
			gateway_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncr_pkg::REG_OWN_IP:  own_ip_q      <= cfg_data;
				ncr_pkg::REG_SUBNET:  subnet_mask_q <= cfg_data;
				ncr_pkg::REG_GATEWAY: gateway_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the item on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind;
			ip_s1   <= ip_addr;
			mac_s1  <= mac_addr;
		end
	end

	ncr_hop u_hop (
		.own_ip       (own_ip_q),
		.subnet_mask  (subnet_mask_q),
		.gateway_addr (gateway_q),
		.dst          (ip_s1),
		.hop          (hop)
	);

	// A learn searches for its own address, a resolve for the chosen next hop.
	assign is_resolve = kind_s1 == ncr_pkg::KIND_RESOLVE;
	assign treq.learn = vld_s1 && !is_resolve;
	assign treq.key   = is_resolve ? hop : ip_s1;
	assign treq.mac   = mac_s1;

	ncr_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (treq),
		.rsp    (trsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	// Fields of the other kind are forced to zero.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q       <= is_resolve && trsp.hit;
			found_mac_q <= is_resolve ? trsp.mac : '0;
			next_hop_q  <= is_resolve ? hop : '0;
			stored_q    <= !is_resolve && trsp.stored;
		end
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign found_mac = found_mac_q;
	assign next_hop  = next_hop_q;
	assign stored    = stored_q;

	// Every transfer shows up as a result strobe once through the item and result registers.
	a_item_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted item produced no result");

	// A result carries either the learn answer or the resolve answer, never both.
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done && stored |-> !hit && found_mac == '0 && next_hop == '0)
		else $error("learn result carries resolve fields");

	// A miss never reports a MAC.
	a_miss_zero_mac: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> found_mac == '0)
		else $error("miss reported a nonzero MAC");

endmodule
